// ===== design/bnme_pkg.sv =====
// Shared constants and types for the bounding-box normalized Morton encoder.
`timescale 1ns / 1ps

package bnme_pkg;

    // Default widths, handed to the top level as parameter defaults.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int AXIS_BITS_DEF   = 21;

    // Fixed port widths.
    localparam int POS_WIDTH  = 32;
    localparam int CODE_WIDTH = 63;
    localparam int AXES       = 3;

    // Action codes carried by an input item.
    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_WIDEN  = 2'd1,
        ACT_ENCODE = 2'd2
    } t_action;

    // Step controls from the sequencer to each axis lane.
    typedef struct packed {
        logic load;   // capture the biased point
        logic prep;   // offset from lower bound, span, low clamp
        logic check;  // high clamp, seed the remainder
        logic step;   // one restoring division step
    } t_lane_ctrl;

endpackage

// ===== design/bnme_axis_div.sv =====
// One axis lane: offset, span and a bit-serial scaled quotient.
`timescale 1ns / 1ps

module bnme_axis_div
    import bnme_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int AXIS_BITS   = AXIS_BITS_DEF
) (
    input  logic                   i_clk,
    input  t_lane_ctrl             i_ctrl,
    input  logic [COORD_WIDTH-1:0] i_point,
    input  logic [COORD_WIDTH-1:0] i_lower,
    input  logic [COORD_WIDTH-1:0] i_upper,
    output logic [AXIS_BITS-1:0]   o_quant
);

    // Largest quantum a point may take: 2^AXIS_BITS - 2.
    localparam logic [AXIS_BITS-1:0] QUANT_CLAMP = {{(AXIS_BITS-1){1'b1}}, 1'b0};

    logic [COORD_WIDTH-1:0] r_point;
    logic [COORD_WIDTH-1:0] r_offset;
    logic [COORD_WIDTH-1:0] r_span;
    logic [COORD_WIDTH-1:0] r_rem;
    logic [AXIS_BITS-1:0]   r_quot;
    logic                   r_at_low;
    logic                   r_at_high;

    logic [COORD_WIDTH:0]   w_rem2;
    logic [COORD_WIDTH-1:0] w_sub;
    logic                   w_ge;
    logic [COORD_WIDTH-1:0] n_rem;

    // The remainder stays below the span, so whichever of the doubled value
    // and the difference is kept fits back into the coordinate width.
    always_comb begin
        w_rem2 = {r_rem, 1'b0};
        w_sub  = w_rem2[COORD_WIDTH-1:0] - r_span;
        w_ge   = (w_rem2 >= {1'b0, r_span});
        n_rem  = w_ge ? w_sub : w_rem2[COORD_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_point <= i_point;
        end
        if (i_ctrl.prep) begin
            r_offset <= r_point - i_lower;
            r_at_low <= (r_point <= i_lower);
            r_span   <= (i_upper == i_lower) ? COORD_WIDTH'(1) : i_upper - i_lower;
        end
        if (i_ctrl.check) begin
            r_at_high <= (r_offset >= r_span);
            r_rem     <= r_offset;
            r_quot    <= '0;
        end
        if (i_ctrl.step) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[AXIS_BITS-2:0], w_ge};
        end
    end

    // The division gives floor(d * 2^B / span); multiplying by 2^B - 1
    // instead takes one off the quotient when the remainder fell below d.
    always_comb begin
        if (r_at_low) begin
            o_quant = '0;
        end else if (r_at_high) begin
            o_quant = QUANT_CLAMP;
        end else if (r_rem >= r_offset) begin
            o_quant = r_quot;
        end else begin
            o_quant = r_quot - AXIS_BITS'(1);
        end
    end

endmodule

// ===== design/bbox_normalized_morton_encoder.sv =====
// Top level of the bounding-box normalized 3-D Morton encoder.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// input    in         i_in_valid / o_in_stall   i_action, i_pos_x, i_pos_y, i_pos_z
// output   out        o_out_valid / i_out_stall o_morton_code, o_no_bounds_error
//
// A start or widen item updates the bounds in the cycle it is accepted and
// gives no result. An encode item passes through the prep, check, division
// and done states before the next item can be accepted; the three axis
// lanes run in parallel, each with a one-bit-per-cycle restoring division.
// An encode item with no bounds set goes straight from idle to done. Reset
// clears the sequencer, the output valid and the bounds flag; the bounds
// themselves hold no reset value. While the output register still holds an
// item that is stalled, a finished encode waits in its last step and the
// input side stays stalled.

module bbox_normalized_morton_encoder
    import bnme_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int AXIS_BITS   = AXIS_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_action,
    input  logic signed [POS_WIDTH-1:0] i_pos_x,
    input  logic signed [POS_WIDTH-1:0] i_pos_y,
    input  logic signed [POS_WIDTH-1:0] i_pos_z,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [CODE_WIDTH-1:0]       o_morton_code,
    output logic                        o_no_bounds_error
);

    localparam int CNT_WIDTH = $clog2(AXIS_BITS);
    localparam logic [COORD_WIDTH-1:0] SIGN_FLIP = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PREP  = 5'b00010,
        S_CHECK = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_WIDTH-1:0] r_cnt, n_cnt;
    logic r_bounds_valid, n_bounds_valid;
    logic r_err, n_err;
    logic r_out_valid, n_out_valid;
    logic [CODE_WIDTH-1:0] r_code;
    logic r_no_bounds;

    logic [AXES-1:0][COORD_WIDTH-1:0] r_lower;
    logic [AXES-1:0][COORD_WIDTH-1:0] r_upper;

    logic [AXES-1:0][COORD_WIDTH-1:0] w_point;
    logic [AXES-1:0][AXIS_BITS-1:0]   w_quant;
    logic [CODE_WIDTH-1:0]            w_code;
    logic                             w_accept;
    logic                             w_out_free;
    logic                             w_restart;
    logic                             w_widen;
    logic                             w_load_out;
    t_lane_ctrl                       w_ctrl;

    // Coordinates are read at COORD_WIDTH bits (sign extended or cut) and
    // turned to offset binary, so that unsigned order is signed order.
    assign w_point[0] = COORD_WIDTH'(i_pos_x) ^ SIGN_FLIP;
    assign w_point[1] = COORD_WIDTH'(i_pos_y) ^ SIGN_FLIP;
    assign w_point[2] = COORD_WIDTH'(i_pos_z) ^ SIGN_FLIP;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // A widen item with no bounds yet behaves as a start item.
    assign w_restart = w_accept && ((i_action == ACT_START) ||
                       ((i_action == ACT_WIDEN) && !r_bounds_valid));
    assign w_widen   = w_accept && (i_action == ACT_WIDEN) && r_bounds_valid;

    assign w_ctrl.load  = w_accept && (i_action == ACT_ENCODE);
    assign w_ctrl.prep  = (r_state == S_PREP);
    assign w_ctrl.check = (r_state == S_CHECK);
    assign w_ctrl.step  = (r_state == S_DIV);

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        bnme_axis_div #(
            .COORD_WIDTH(COORD_WIDTH),
            .AXIS_BITS  (AXIS_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_point(w_point[a]),
            .i_lower(r_lower[a]),
            .i_upper(r_upper[a]),
            .o_quant(w_quant[a])
        );
    end

    // Bit interleave: x to 3i, y to 3i+1, z to 3i+2; upper bits stay zero
    // when the axis width is below its maximum.
    always_comb begin
        w_code = '0;
        for (int i = 0; i < AXIS_BITS; i++) begin
            for (int a = 0; a < AXES; a++) begin
                w_code[3*i+a] = w_quant[a][i];
            end
        end
    end

    // Sequencer.
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_bounds_valid = r_bounds_valid;
        n_err          = r_err;
        w_load_out     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_restart) begin
                    n_bounds_valid = 1'b1;
                end
                if (w_accept && (i_action == ACT_ENCODE)) begin
                    n_err   = !r_bounds_valid;
                    n_state = r_bounds_valid ? S_PREP : S_DONE;
                end
            end
            S_PREP: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_cnt   = CNT_WIDTH'(AXIS_BITS - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt - CNT_WIDTH'(1);
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_bounds_valid <= 1'b0;
            r_err          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_cnt          <= n_cnt;
            r_bounds_valid <= n_bounds_valid;
            r_err          <= n_err;
            r_out_valid    <= n_out_valid;
        end
    end

    // Output register; an encode with no bounds reports a zero code.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_code      <= r_err ? '0 : w_code;
            r_no_bounds <= r_err;
        end
    end

    // Bounds per axis, kept in offset binary.
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AXES; a++) begin
            if (w_restart) begin
                r_lower[a] <= w_point[a];
                r_upper[a] <= w_point[a];
            end else if (w_widen) begin
                if (w_point[a] < r_lower[a]) begin
                    r_lower[a] <= w_point[a];
                end
                if (w_point[a] > r_upper[a]) begin
                    r_upper[a] <= w_point[a];
                end
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_morton_code     = r_code;
    assign o_no_bounds_error = r_no_bounds;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the bounding-box normalized Morton encoder.
`timescale 1ns / 1ps

module tb;
    import bnme_pkg::*;

    // Widths used by the predictor; the block runs with its defaults.
    localparam int AXIS_BITS = AXIS_BITS_DEF;
    localparam logic [63:0] QMAX = (64'd1 << AXIS_BITS) - 64'd1;
    localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

    // Action code 3 is not part of the package enum; the block must ignore it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Cycles with no handshake on either side before the run is declared hung.
    // The slowest legal gap is an encode behind a long receiver stall plus a
    // long sender gap.
    localparam int HANG_LIMIT = 2000;
    // Settling time after the last expected code, a bit over one encode.
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1700;

    // One expected output item.
    typedef struct {
        logic [CODE_WIDTH-1:0] code;
        logic                  err;
    } t_code_exp;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [1:0]                  i_action = ACT_START;
    logic signed [POS_WIDTH-1:0] i_pos_x = '0;
    logic signed [POS_WIDTH-1:0] i_pos_y = '0;
    logic signed [POS_WIDTH-1:0] i_pos_z = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [CODE_WIDTH-1:0]       o_morton_code;
    logic                        o_no_bounds_error;

    // Predictor state: per-axis bounds in offset-binary form, so that an
    // unsigned compare gives signed order, plus the flag that a set exists.
    logic [31:0] bnd_lo [AXES];
    logic [31:0] bnd_hi [AXES];
    logic        bnd_set = 1'b0;

    t_code_exp pending_codes[$];
    t_code_exp head_code;
    int        errors = 0;
    int        items_sent = 0;
    int        idle_cycles = 0;
    int        stall_left = 0;
    bit        idle_en = 1'b1;

    bbox_normalized_morton_encoder u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_morton_code     (o_morton_code),
        .o_no_bounds_error (o_no_bounds_error)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Quantize one biased coordinate against the biased bounds of its axis.
    // The scaled offset d * QMAX stays below 2^53, so a plain 64-bit divide
    // gives the exact floor that the hardware reaches bit by bit.
    function automatic logic [AXIS_BITS-1:0] axis_quantum(logic [31:0] v,
                                                          logic [31:0] lo,
                                                          logic [31:0] hi);
        logic [63:0] span;
        logic [63:0] offs;
        span = (hi > lo) ? (64'(hi) - 64'(lo)) : 64'd1;
        if (v <= lo)
            return '0;
        offs = 64'(v) - 64'(lo);
        if (offs >= span)
            return AXIS_BITS'(QMAX - 64'd1);
        return AXIS_BITS'((offs * QMAX) / span);
    endfunction

    // Update the bounds or queue the code that an accepted item must produce.
    task automatic predict_morton(logic [1:0] act, logic [31:0] px,
                                  logic [31:0] py, logic [31:0] pz);
        logic [31:0]           pt [AXES];
        logic [AXIS_BITS-1:0]  q [AXES];
        t_code_exp             exp_code;
        pt[0] = px ^ SIGN_FLIP;
        pt[1] = py ^ SIGN_FLIP;
        pt[2] = pz ^ SIGN_FLIP;
        exp_code.code = '0;
        exp_code.err = 1'b0;
        // A widen with no set yet behaves exactly like a start.
        if (act == ACT_START || (act == ACT_WIDEN && !bnd_set)) begin
            for (int a = 0; a < AXES; a++) begin
                bnd_lo[a] = pt[a];
                bnd_hi[a] = pt[a];
            end
            bnd_set = 1'b1;
        end else if (act == ACT_WIDEN) begin
            for (int a = 0; a < AXES; a++) begin
                if (pt[a] < bnd_lo[a])
                    bnd_lo[a] = pt[a];
                if (pt[a] > bnd_hi[a])
                    bnd_hi[a] = pt[a];
            end
        end else if (act == ACT_ENCODE) begin
            if (!bnd_set) begin
                exp_code.err = 1'b1;
            end else begin
                for (int a = 0; a < AXES; a++)
                    q[a] = axis_quantum(pt[a], bnd_lo[a], bnd_hi[a]);
                // x lands on bit 3i, y on 3i+1, z on 3i+2.
                for (int i = 0; i < AXIS_BITS; i++)
                    for (int a = 0; a < AXES; a++)
                        exp_code.code[3*i+a] = q[a][i];
            end
            pending_codes = {pending_codes, exp_code};
        end
        // The unused action code changes nothing and gives no result.
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Sender gap after an item: mostly none, sometimes a few cycles,
    // rarely a long pause. With idling off, items go back to back.
    function automatic int sender_gap();
        int r;
        if (!idle_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item, hold it until the block takes it, then predict it.
    // Valid is only lowered when a gap follows, so back-to-back items never
    // see two assignments to valid in one time step.
    task automatic send_item(logic [1:0] act, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz);
        int gap;
        i_in_valid <= 1'b1;
        i_action <= act;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_morton(act, px, py, pz);
        if (act != ACT_UNUSED)
            items_sent++;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: receiver stall pattern, then the scoreboard check.
    // ------------------------------------------------------------------

    // Stall runs in bursts: open runs, short stalls and the odd long stall.
    // Turning idling off leaves the output wide open.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!idle_en) begin
            i_out_stall <= 1'b0;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    i_out_stall <= 1'b0;
                    stall_left <= $urandom_range(0, 6);
                end
                6, 7, 8: begin
                    i_out_stall <= 1'b1;
                    stall_left <= $urandom_range(0, 2);
                end
                default: begin
                    i_out_stall <= 1'b1;
                    stall_left <= $urandom_range(20, 60);
                end
            endcase
        end
    end

    // Every accepted code is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_codes.size() == 0) begin
                $error("unexpected result: morton_code %h no_bounds_error %b",
                       o_morton_code, o_no_bounds_error);
                errors++;
            end else begin
                head_code = pending_codes.pop_front();
                if (o_morton_code !== head_code.code) begin
                    $error("morton_code: expected %h, actual %h",
                           head_code.code, o_morton_code);
                    errors++;
                end
                if (o_no_bounds_error !== head_code.err) begin
                    $error("no_bounds_error: expected %b, actual %b",
                           head_code.err, o_no_bounds_error);
                    errors++;
                end
            end
        end
    end

    // Hang detector: any handshake on either side restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset there are no bounds. Encodes must flag the error,
    // the unused action must be ignored, and a widen must open a new set.
    task automatic test_no_bounds();
        send_item(ACT_ENCODE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(ACT_UNUSED, 32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item(ACT_ENCODE, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
        send_item(ACT_WIDEN, 32'd100, -32'sd7, 32'd0);
        // Degenerate set: the point itself gives zero, one step above gives
        // the top quantum on every axis.
        send_item(ACT_ENCODE, 32'd100, -32'sd7, 32'd0);
        send_item(ACT_ENCODE, 32'd101, -32'sd6, 32'd1);
        send_item(ACT_ENCODE, 32'd99, -32'sd8, -32'sd1);
    endtask

    // Hand-picked points around the bounds and at the coordinate extremes.
    task automatic test_bound_edges();
        send_item(ACT_START, -32'sd100, -32'sd100, -32'sd100);
        send_item(ACT_WIDEN, 32'sd100, 32'sd100, 32'sd100);
        send_item(ACT_UNUSED, 32'sd5000, -32'sd5000, 32'sd0);
        send_item(ACT_ENCODE, -32'sd100, 32'sd100, 32'sd0);
        send_item(ACT_ENCODE, -32'sd99, 32'sd99, 32'sd1);
        send_item(ACT_ENCODE, -32'sd1000, 32'sd1000, -32'sd1);
        send_item(ACT_ENCODE, 32'h8000_0000, 32'h7FFF_FFFF, 32'sd50);
        // Widest span the coordinates allow.
        send_item(ACT_START, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(ACT_WIDEN, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(ACT_ENCODE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(ACT_ENCODE, 32'h0000_0000, 32'h7FFF_FFFE, 32'h8000_0001);
        send_item(ACT_ENCODE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001);
        // Spans of one and two units on different axes.
        send_item(ACT_START, 32'sd0, 32'sd10, -32'sd3);
        send_item(ACT_WIDEN, 32'sd1, 32'sd12, -32'sd3);
        send_item(ACT_ENCODE, 32'sd1, 32'sd11, -32'sd3);
        send_item(ACT_ENCODE, 32'sd0, 32'sd12, -32'sd2);
    endtask

    // Pick a point for a bound item around a per-axis anchor.
    function automatic logic [31:0] point_near(logic [31:0] anchor, int spread);
        case (spread)
            0: return $urandom;
            1: return anchor + $urandom_range(0, 2000) - 32'd1000;
            2: return anchor + $urandom_range(0, 1 << 22);
            default: return anchor + $urandom_range(0, 3);
        endcase
    endfunction

    // Pick an encode coordinate for one axis from the current bounds:
    // the bounds themselves, just outside them, anywhere, or inside.
    function automatic logic [31:0] point_to_encode(int a);
        logic [31:0] lo_raw;
        logic [31:0] hi_raw;
        logic [63:0] span;
        lo_raw = bnd_lo[a] ^ SIGN_FLIP;
        hi_raw = bnd_hi[a] ^ SIGN_FLIP;
        span = 64'(bnd_hi[a]) - 64'(bnd_lo[a]);
        case ($urandom_range(0, 11))
            0: return lo_raw;
            1: return hi_raw;
            2: return lo_raw - 32'd1;
            3: return hi_raw + 32'd1;
            4: return $urandom;
            default: return (bnd_lo[a] + 32'({$urandom, $urandom} % (span + 64'd1)))
                            ^ SIGN_FLIP;
        endcase
    endfunction

    // Mostly well-formed point sets: a start, some widens, then a run of
    // encodes. A few sets are broken up by stray items in the middle.
    task automatic test_random_sets(int target);
        logic [31:0] anchor [AXES];
        logic [31:0] pt [AXES];
        int          spread [AXES];
        int          n_widen;
        int          n_encode;
        int          stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            idle_en = ($urandom_range(0, 4) != 0);
            for (int a = 0; a < AXES; a++) begin
                anchor[a] = $urandom;
                spread[a] = $urandom_range(0, 3);
            end
            // Occasionally skip the start, so the widens extend the old set.
            if ($urandom_range(0, 15) != 0)
                send_item(ACT_START, point_near(anchor[0], spread[0]),
                          point_near(anchor[1], spread[1]),
                          point_near(anchor[2], spread[2]));
            n_widen = $urandom_range(0, 6);
            for (int k = 0; k < n_widen; k++)
                send_item(ACT_WIDEN, point_near(anchor[0], spread[0]),
                          point_near(anchor[1], spread[1]),
                          point_near(anchor[2], spread[2]));
            n_encode = $urandom_range(1, 8);
            for (int k = 0; k < n_encode; k++) begin
                if ($urandom_range(0, 24) == 0)
                    send_item(ACT_UNUSED, $urandom, $urandom, $urandom);
                for (int a = 0; a < AXES; a++)
                    pt[a] = point_to_encode(a);
                send_item(ACT_ENCODE, pt[0], pt[1], pt[2]);
            end
            // Noise: a fully random item of any action between sets.
            if ($urandom_range(0, 9) == 0)
                send_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        end
        idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_bounds();
        test_bound_edges();
        test_random_sets(RANDOM_ITEMS);

        i_in_valid <= 1'b0;
        // Wait for every predicted code, then give the block time to show
        // any stray result. The hang detector bounds this wait.
        while (pending_codes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && pending_codes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/bnme_pkg.sv
design/bnme_axis_div.sv
design/bbox_normalized_morton_encoder.sv
verif/tb.sv
